// ----- sv/stvg_pkg.sv -----
// Shared types, register codes and helper functions for the Sierpinski leaf generator.
// No dependencies; used by stvg_front, stvg_cell and sierpinski_triangle_vertex_gen.
`default_nettype none

package stvg_pkg;

   localparam int INDEX_W    = 16;
   localparam int COORD_W    = 17;
   localparam int SHADE_W    = 17;
   localparam int DEPTH_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] REG_DEPTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_A_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_B_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_C_X   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_C_Y   = 3'd6;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } stvg_point_type;

   typedef struct packed {
      stvg_point_type a;
      stvg_point_type b;
      stvg_point_type c;
   } stvg_corners_type;

   typedef struct packed {
      logic                 invalid;
      logic [INDEX_W-1:0]   rem;
      stvg_corners_type     corners;
      logic [SHADE_W-1:0]   shade;
      logic [SHADE_W-1:0]   shade_next;
      logic [SHADE_W-1:0]   shade_inverse;
   } stvg_item_type;

   function automatic longint unsigned pow3(input int n);
      longint unsigned acc;
      acc = 64'd1;
      for (int k = 0; k < n; k++) begin
         acc = acc * 64'd3;
      end
      return acc;
   endfunction

   // floor((p + q) / 2) per axis
   function automatic stvg_point_type midpoint(input stvg_point_type p, input stvg_point_type q);
      logic signed [COORD_W:0] sx;
      logic signed [COORD_W:0] sy;
      stvg_point_type m;
      sx = (COORD_W+1)'(p.x) + (COORD_W+1)'(q.x);
      sy = (COORD_W+1)'(p.y) + (COORD_W+1)'(q.y);
      m.x = sx[COORD_W:1];
      m.y = sy[COORD_W:1];
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- sv/sierpinski_triangle_vertex_gen.sv -----
// Sierpinski leaf generator: index check and shade stages, then one cell per
// subdivision level. Depends on stvg_pkg, stvg_front and stvg_cell.
//
// Usage:
//   req_valid/req_ready carry one leaf index per request; rsp_valid/rsp_ready
//   return the leaf's three corners, three shades and an index_invalid flag.
//   An index at or beyond 3^depth returns zeros with index_invalid set.
//   csr_write_en/csr_index/csr_wdata write the depth and base corners; write
//   only while no request is in flight.
// Timing:
//   A request passes four entry stages (range check, two multiplier
//   stages, correction) and then one cell per subdivision level, the last
//   cell being the response register.
//   One request per cycle is taken while the response side keeps up.
// Stall:
//   While a response waits with rsp_ready low, the whole chain holds and
//   req_ready is low.
// Reset:
//   Empties the chain and loads depth 0 and the default base triangle.
`default_nettype none

module sierpinski_triangle_vertex_gen #(
   parameter int MAX_DEPTH     = 10,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [stvg_pkg::INDEX_W-1:0]          req_leaf_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_first_x,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_first_y,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_second_x,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_second_y,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_third_x,
   output logic signed [stvg_pkg::COORD_W-1:0]        rsp_third_y,
   output logic [stvg_pkg::SHADE_W-1:0]               rsp_shade,
   output logic [stvg_pkg::SHADE_W-1:0]               rsp_shade_next,
   output logic [stvg_pkg::SHADE_W-1:0]               rsp_shade_inverse,
   output logic                                       rsp_index_invalid,
   input  wire logic                                  csr_write_en,
   input  wire logic [stvg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [stvg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int DW = $clog2(MAX_DEPTH + 1);

   logic [stvg_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   stvg_pkg::stvg_corners_type   base_ff, base_in;
   logic [DW-1:0]                depth_sat;
   logic [MAX_DEPTH-1:0]         cell_active;
   logic                         advance;

   logic                    chain_valid [MAX_DEPTH+1];
   stvg_pkg::stvg_item_type chain_item  [MAX_DEPTH+1];
   stvg_pkg::stvg_item_type last_item;

   always_comb begin
      depth_in = depth_ff;
      base_in  = base_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            stvg_pkg::REG_DEPTH: depth_in  = csr_wdata[stvg_pkg::DEPTH_W-1:0];
            stvg_pkg::REG_A_X:   base_in.a.x = csr_wdata;
            stvg_pkg::REG_A_Y:   base_in.a.y = csr_wdata;
            stvg_pkg::REG_B_X:   base_in.b.x = csr_wdata;
            stvg_pkg::REG_B_Y:   base_in.b.y = csr_wdata;
            stvg_pkg::REG_C_X:   base_in.c.x = csr_wdata;
            stvg_pkg::REG_C_Y:   base_in.c.y = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         base_ff.a.x <= -17'sd32768;
         base_ff.a.y <= -17'sd32768;
         base_ff.b.x <= 17'sd32768;
         base_ff.b.y <= -17'sd32768;
         base_ff.c.x <= 17'sd0;
         base_ff.c.y <= 17'sd32768;
      end else begin
         depth_ff <= depth_in;
         base_ff  <= base_in;
      end
   end

   assign depth_sat = (depth_ff > stvg_pkg::DEPTH_W'(MAX_DEPTH)) ?
                      DW'(MAX_DEPTH) : DW'(depth_ff);

   assign advance   = !chain_valid[MAX_DEPTH] || rsp_ready;
   assign req_ready = advance;

   stvg_front #(
      .MAX_DEPTH     (MAX_DEPTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_index  (req_leaf_index),
      .depth_sat (depth_sat),
      .base      (base_ff),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0])
   );

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
      assign cell_active[i] = (depth_sat >= DW'(MAX_DEPTH - i));

      stvg_cell #(
         .PLACE (stvg_pkg::pow3(MAX_DEPTH - 1 - i))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .active    (cell_active[i]),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   assign last_item = chain_item[MAX_DEPTH];
   assign rsp_valid = chain_valid[MAX_DEPTH];

   always_comb begin
      rsp_index_invalid = last_item.invalid;
      if (last_item.invalid) begin
         rsp_first_x       = '0;
         rsp_first_y       = '0;
         rsp_second_x      = '0;
         rsp_second_y      = '0;
         rsp_third_x       = '0;
         rsp_third_y       = '0;
         rsp_shade         = '0;
         rsp_shade_next    = '0;
         rsp_shade_inverse = '0;
      end else begin
         rsp_first_x       = last_item.corners.a.x;
         rsp_first_y       = last_item.corners.a.y;
         rsp_second_x      = last_item.corners.b.x;
         rsp_second_y      = last_item.corners.b.y;
         rsp_third_x       = last_item.corners.c.x;
         rsp_third_y       = last_item.corners.c.y;
         rsp_shade         = last_item.shade;
         rsp_shade_next    = last_item.shade_next;
         rsp_shade_inverse = last_item.shade_inverse;
      end
   end

   ast_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   ast_shade_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_invalid && (FRACTION_BITS <= 16))
      |-> (rsp_shade <= rsp_shade_next))
      else $error("shade exceeds next shade");

   ast_shade_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_invalid && (FRACTION_BITS <= 16))
      |-> (({1'b0, rsp_shade} + {1'b0, rsp_shade_inverse}) == (18'd1 << FRACTION_BITS)))
      else $error("shade and inverse do not sum to one");

endmodule

`default_nettype wire

// ----- sv/stvg_front.sv -----
// Entry stages: range check of the leaf index and the two shade quotients
// by reciprocal multiply with one correction step. Depends on stvg_pkg.
`default_nettype none

module stvg_front #(
   parameter int MAX_DEPTH     = 10,
   parameter int FRACTION_BITS = 16,
   localparam int DW           = $clog2(MAX_DEPTH + 1)
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               in_valid,
   input  wire logic [stvg_pkg::INDEX_W-1:0]       in_index,
   input  wire logic [DW-1:0]                      depth_sat,
   input  wire stvg_pkg::stvg_corners_type         base,
   output logic                                    out_valid,
   output stvg_pkg::stvg_item_type                 out_item
);

   localparam int IW = stvg_pkg::INDEX_W;
   localparam int SW = stvg_pkg::SHADE_W;
   localparam int LW = $clog2(stvg_pkg::pow3(MAX_DEPTH) + 1);
   localparam int RW = FRACTION_BITS + 15;
   localparam int PW = IW + 1 + RW;
   localparam int QW = FRACTION_BITS + 1;
   localparam int MW = QW + LW;
   localparam int NW = IW + 1 + FRACTION_BITS;
   localparam int CW = FRACTION_BITS + IW + LW + 3;

   logic [LW-1:0] leaves_tab [MAX_DEPTH+1];
   logic [RW-1:0] recip_tab  [MAX_DEPTH+1];

   for (genvar d = 0; d <= MAX_DEPTH; d++) begin : g_tab
      localparam longint unsigned P3 = stvg_pkg::pow3(d);
      localparam longint unsigned RC = (d == 0) ? 64'd0 :
                                       (64'd1 << (FRACTION_BITS + 16)) / P3;
      assign leaves_tab[d] = LW'(P3);
      assign recip_tab[d]  = RW'(RC);
   end

   logic [LW-1:0] leaves;
   logic [RW-1:0] recip;
   logic          depth_zero;

   assign leaves     = leaves_tab[depth_sat];
   assign recip      = recip_tab[depth_sat];
   assign depth_zero = (depth_sat == '0);

   logic          s1_valid_ff;
   logic [IW-1:0] s1_index_ff;
   logic          s1_invalid_ff;
   logic          s1_invalid_in;

   logic          s2_valid_ff;
   logic [IW-1:0] s2_index_ff;
   logic          s2_invalid_ff;
   logic [PW-1:0] s2_prod0_ff, s2_prod0_in;
   logic [PW-1:0] s2_prod1_ff, s2_prod1_in;

   logic          s3_valid_ff;
   logic [IW-1:0] s3_index_ff;
   logic          s3_invalid_ff;
   logic [QW-1:0] s3_quot0_ff, s3_quot0_in;
   logic [QW-1:0] s3_quot1_ff, s3_quot1_in;
   logic [MW-1:0] s3_mult0_ff, s3_mult0_in;
   logic [MW-1:0] s3_mult1_ff, s3_mult1_in;

   logic                    s4_valid_ff;
   stvg_pkg::stvg_item_type s4_item_ff, s4_item_in;

   logic [CW-1:0] num0, num1, lim0, lim1;
   logic [QW-1:0] q0, q1;

   assign s1_invalid_in = (64'(in_index) >= 64'(leaves));

   assign s2_prod0_in = PW'(s1_index_ff) * PW'(recip);
   assign s2_prod1_in = (PW'(s1_index_ff) + PW'(1)) * PW'(recip);

   assign s3_quot0_in = s2_prod0_ff[16 +: QW];
   assign s3_quot1_in = s2_prod1_ff[16 +: QW];
   assign s3_mult0_in = MW'(s3_quot0_in) * MW'(leaves);
   assign s3_mult1_in = MW'(s3_quot1_in) * MW'(leaves);

   always_comb begin
      num0 = CW'(s3_index_ff) << FRACTION_BITS;
      num1 = (CW'(s3_index_ff) + CW'(1)) << FRACTION_BITS;
      lim0 = CW'(s3_mult0_ff) + CW'(leaves);
      lim1 = CW'(s3_mult1_ff) + CW'(leaves);
      q0   = s3_quot0_ff + QW'(num0 >= lim0);
      q1   = s3_quot1_ff + QW'(num1 >= lim1);
      if (depth_zero) begin
         q0 = '0;
         q1 = QW'(1) << FRACTION_BITS;
      end
      s4_item_in.invalid       = s3_invalid_ff;
      s4_item_in.rem           = s3_index_ff;
      s4_item_in.corners       = base;
      s4_item_in.shade         = SW'(q0);
      s4_item_in.shade_next    = SW'(q1);
      s4_item_in.shade_inverse = SW'((QW'(1) << FRACTION_BITS) - q0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_index_ff   <= in_index;
         s1_invalid_ff <= s1_invalid_in;
         s2_index_ff   <= s1_index_ff;
         s2_invalid_ff <= s1_invalid_ff;
         s2_prod0_ff   <= s2_prod0_in;
         s2_prod1_ff   <= s2_prod1_in;
         s3_index_ff   <= s2_index_ff;
         s3_invalid_ff <= s2_invalid_ff;
         s3_quot0_ff   <= s3_quot0_in;
         s3_quot1_ff   <= s3_quot1_in;
         s3_mult0_ff   <= s3_mult0_in;
         s3_mult1_ff   <= s3_mult1_in;
         s4_item_ff    <= s4_item_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_item  = s4_item_ff;

endmodule

`default_nettype wire

// ----- sv/stvg_cell.sv -----
// One subdivision level: when active, takes the next base-3 digit off the index
// remainder and keeps the chosen corner sub-triangle; otherwise passes the item through. Depends on stvg_pkg.
`default_nettype none

module stvg_cell #(
   parameter longint unsigned PLACE = 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    active,
   input  wire logic                    in_valid,
   input  wire stvg_pkg::stvg_item_type in_item,
   output logic                         out_valid,
   output stvg_pkg::stvg_item_type      out_item
);

   localparam int IW = stvg_pkg::INDEX_W;
   localparam longint unsigned PLACE2 = 2 * PLACE;
   localparam logic [IW-1:0] REM_P  = IW'(PLACE);
   localparam logic [IW-1:0] REM_P2 = IW'(PLACE2);

   localparam logic [1:0] DIGIT_A = 2'd0;
   localparam logic [1:0] DIGIT_B = 2'd1;
   localparam logic [1:0] DIGIT_C = 2'd2;

   logic                    valid_ff;
   stvg_pkg::stvg_item_type item_ff, item_in;
   logic [1:0]              digit;
   stvg_pkg::stvg_point_type mid_ab, mid_bc, mid_ca;

   always_comb begin
      priority if (64'(in_item.rem) >= PLACE2) begin
         digit = DIGIT_C;
      end else if (64'(in_item.rem) >= PLACE) begin
         digit = DIGIT_B;
      end else begin
         digit = DIGIT_A;
      end
      mid_ab  = stvg_pkg::midpoint(in_item.corners.a, in_item.corners.b);
      mid_bc  = stvg_pkg::midpoint(in_item.corners.b, in_item.corners.c);
      mid_ca  = stvg_pkg::midpoint(in_item.corners.c, in_item.corners.a);
      item_in = in_item;
      if (active) begin
         unique case (digit)
            DIGIT_A: begin
               item_in.corners.b = mid_ab;
               item_in.corners.c = mid_ca;
            end
            DIGIT_B: begin
               item_in.corners.a = mid_ab;
               item_in.corners.c = mid_bc;
               item_in.rem       = in_item.rem - REM_P;
            end
            default: begin
               item_in.corners.a = mid_ca;
               item_in.corners.b = mid_bc;
               item_in.rem       = in_item.rem - REM_P2;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire
